/* rtl/vgss_pkg.sv */
// shared types, constants and lookup tables for the vfd grid scan shifter
`default_nettype none

package vgss_pkg;

  localparam int NUM_GRIDS     = 7;
  localparam int BITS_PER_BYTE = 8;
  localparam int CHAIN_BYTES   = 4;
  localparam int GRID_STORE    = 7;
  localparam int GRID_AW       = $clog2(GRID_STORE);
  localparam int BSEL_W        = $clog2(CHAIN_BYTES);
  localparam int BITS_W        = 4;

  localparam logic [3:0] BLANK_DIGIT = 4'hA;
  localparam logic [7:0] FRAME3_BASE = 8'h02;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_DIGIT  = 2'd1,
    CMD_SYMBOL = 2'd2,
    CMD_BLANK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_BUILD = 3'd0,
    PH_CLEAR = 3'd1,
    PH_LOAD  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CLKHI = 3'd4,
    PH_LATCH = 3'd5
  } phase_t;

  // bit 0 is serial_data
  typedef struct packed {
    logic clear_n;
    logic latch_clock;
    logic shift_clock;
    logic serial_data;
  } pin_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [1:0] sym_sel;
    logic [7:0] sym_bits;
  } grid_entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [GRID_AW-1:0] rd_addr;
    logic               dig_we;
    logic [GRID_AW-1:0] dig_addr;
    logic [3:0]         dig_data;
    logic               sym_we;
    logic [GRID_AW-1:0] sym_addr;
    logic [1:0]         sym_sel;
    logic [7:0]         sym_bits;
    logic               blank;
  } store_req_t;

  typedef struct packed {
    logic [3:0] grid;
    logic [1:0] sel;
    logic [7:0] bits;
  } sym_ent_t;

  // {frame byte 1, frame byte 0}
  function automatic logic [15:0] seg_lookup(input logic [3:0] d);
    logic [15:0] v;
    unique case (d)
      4'd0:    v = 16'h806D;
      4'd1:    v = 16'h0028;
      4'd2:    v = 16'h2065;
      4'd3:    v = 16'h206C;
      4'd4:    v = 16'hA028;
      4'd5:    v = 16'hA04C;
      4'd6:    v = 16'hA04D;
      4'd7:    v = 16'h0068;
      4'd8:    v = 16'hA06D;
      4'd9:    v = 16'hA06C;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // {frame byte select, grid enable bits}
  function automatic logic [9:0] grid_lookup(input logic [GRID_AW-1:0] g);
    logic [9:0] v;
    unique case (g)
      3'd0:    v = {2'd2, 8'h04};
      3'd1:    v = {2'd2, 8'h20};
      3'd2:    v = {2'd1, 8'h01};
      3'd3:    v = {2'd1, 8'h10};
      3'd4:    v = {2'd1, 8'h40};
      3'd5:    v = {2'd0, 8'h02};
      3'd6:    v = {2'd0, 8'h10};
      default: v = {2'd2, 8'h04};
    endcase
    return v;
  endfunction

  function automatic sym_ent_t sym_lookup(input logic [2:0] id);
    sym_ent_t v;
    unique case (id)
      3'd0: v = '{grid: 4'd1, sel: 2'd2, bits: 8'h80};
      3'd1: v = '{grid: 4'd2, sel: 2'd2, bits: 8'h40};
      3'd2: v = '{grid: 4'd0, sel: 2'd1, bits: 8'h02};
      3'd3: v = '{grid: 4'd3, sel: 2'd2, bits: 8'h08};
      3'd4: v = '{grid: 4'd4, sel: 2'd2, bits: 8'h02};
      3'd5: v = '{grid: 4'd5, sel: 2'd2, bits: 8'h01};
      3'd6: v = '{grid: 4'd6, sel: 2'd2, bits: 8'h08};
      3'd7: v = '{grid: 4'd6, sel: 2'd0, bits: 8'h80};
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/vgss_store.sv */
// per-grid digit and symbol memories with valid bits and write forwarding
`default_nettype none

module vgss_store (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vgss_pkg::store_req_t req,
  output vgss_pkg::grid_entry_t     entry
);
  import vgss_pkg::*;

  logic [3:0]          dig_mem [GRID_STORE];
  logic [9:0]          sym_mem [GRID_STORE];
  logic [GRID_STORE-1:0] dig_vld_r;
  logic [GRID_STORE-1:0] sym_vld_r;
  logic [3:0]          dig_rd_r;
  logic [9:0]          sym_rd_r;
  logic [GRID_AW-1:0]  rd_addr_r;
  logic                fwd_dig_r;
  logic                fwd_sym_r;
  logic [3:0]          fwd_dig_data_r;
  logic [9:0]          fwd_sym_data_r;

  always_ff @(posedge clk) begin
    if (req.dig_we) begin
      dig_mem[req.dig_addr] <= req.dig_data;
    end
    if (req.sym_we) begin
      sym_mem[req.sym_addr] <= {req.sym_sel, req.sym_bits};
    end
    if (req.rd_en) begin
      dig_rd_r       <= dig_mem[req.rd_addr];
      sym_rd_r       <= sym_mem[req.rd_addr];
      rd_addr_r      <= req.rd_addr;
      fwd_dig_data_r <= req.dig_data;
      fwd_sym_data_r <= {req.sym_sel, req.sym_bits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_vld_r <= '0;
      sym_vld_r <= '0;
      fwd_dig_r <= 1'b0;
      fwd_sym_r <= 1'b0;
    end else begin
      if (req.blank) begin
        dig_vld_r <= '0;
        sym_vld_r <= '0;
      end else begin
        if (req.dig_we) dig_vld_r[req.dig_addr] <= 1'b1;
        if (req.sym_we) sym_vld_r[req.sym_addr] <= 1'b1;
      end
      // read-first memory: catch a write landing on the entry being read
      if (req.rd_en) begin
        fwd_dig_r <= req.dig_we && (req.dig_addr == req.rd_addr);
        fwd_sym_r <= req.sym_we && (req.sym_addr == req.rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_dig_r) entry.digit = fwd_dig_data_r;
    else if (dig_vld_r[rd_addr_r]) entry.digit = dig_rd_r;
    else entry.digit = BLANK_DIGIT;

    if (fwd_sym_r) {entry.sym_sel, entry.sym_bits} = fwd_sym_data_r;
    else if (sym_vld_r[rd_addr_r]) {entry.sym_sel, entry.sym_bits} = sym_rd_r;
    else {entry.sym_sel, entry.sym_bits} = '0;
  end

  a_blank_clears: assert property (@(posedge clk) disable iff (!rst_n)
    req.blank |=> (dig_vld_r == '0) && (sym_vld_r == '0))
    else $error("blank did not clear the valid bits");

  a_fwd_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (req.rd_en && req.dig_we && req.dig_addr == req.rd_addr) |=> fwd_dig_r)
    else $error("digit write to the entry under read not forwarded");

  a_sym_fwd_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (req.rd_en && req.sym_we && req.sym_addr == req.rd_addr) |=> fwd_sym_r)
    else $error("symbol write to the entry under read not forwarded");

endmodule

`default_nettype wire

/* rtl/vgss_seq.sv */
// scan sequencer: frame build, byte load, bit shifting and pin levels
`default_nettype none

module vgss_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  fire,
  input  wire vgss_pkg::cmd_t        cmd,
  input  wire logic [2:0]            position,
  input  wire logic [3:0]            digit,
  input  wire logic [2:0]            symbol_id,
  input  wire vgss_pkg::grid_entry_t entry,
  output vgss_pkg::store_req_t       req,
  output vgss_pkg::pin_t             pins_nxt
);
  import vgss_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          frame_r   [CHAIN_BYTES];
  logic [7:0]          frame_nxt [CHAIN_BYTES];
  logic [7:0]          build     [CHAIN_BYTES];
  logic [BSEL_W-1:0]   bsel_r, bsel_nxt;
  logic [GRID_AW-1:0]  grid_r, grid_nxt;
  logic [GRID_AW-1:0]  grid_cur;
  logic [7:0]          shift_r, shift_nxt;
  logic [BITS_W-1:0]   bits_r, bits_nxt, bits_dec;
  pin_t                pins_r;
  logic                tick;
  logic [15:0]         seg;
  logic [9:0]          gent;
  sym_ent_t            sent;

  assign tick     = fire && (cmd == CMD_TICK);
  assign grid_cur = (grid_r >= GRID_AW'(GRID_STORE)) ? '0 : grid_r;
  assign bits_dec = bits_r - 1'b1;
  assign seg      = seg_lookup(entry.digit);
  assign gent     = grid_lookup(grid_cur);
  assign sent     = sym_lookup(symbol_id);

  always_comb begin
    for (int i = 0; i < CHAIN_BYTES; i++) begin
      build[i] = (i == 0) ? seg[7:0] : (i == 1) ? seg[15:8] :
                 (i == 3) ? FRAME3_BASE : 8'h00;
      if (gent[9:8] == BSEL_W'(i)) build[i] = build[i] | gent[7:0];
      if (entry.sym_sel == BSEL_W'(i)) build[i] = build[i] | entry.sym_bits;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (tick) begin
      unique case (phase_r)
        PH_CLEAR: phase_nxt = PH_LOAD;
        PH_LOAD:  phase_nxt = PH_DATA;
        PH_DATA:  phase_nxt = PH_CLKHI;
        PH_CLKHI: phase_nxt = (bits_dec != '0) ? PH_DATA : PH_LATCH;
        PH_LATCH: phase_nxt = (bsel_r == '0) ? PH_BUILD : PH_LOAD;
        default:  phase_nxt = PH_CLEAR;
      endcase
    end
  end

  // datapath and pins
  always_comb begin
    frame_nxt = frame_r;
    bsel_nxt  = bsel_r;
    grid_nxt  = grid_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    pins_nxt  = pins_r;
    if (tick) begin
      unique case (phase_r)
        PH_CLEAR: pins_nxt.clear_n = 1'b1;
        PH_LOAD: begin
          shift_nxt = frame_r[bsel_r];
          bsel_nxt  = bsel_r + 1'b1;
          bits_nxt  = BITS_W'(BITS_PER_BYTE);
        end
        PH_DATA: begin
          pins_nxt.serial_data = shift_r[0];
          pins_nxt.shift_clock = 1'b0;
        end
        PH_CLKHI: begin
          shift_nxt = shift_r >> 1;
          bits_nxt  = bits_dec;
          pins_nxt.shift_clock = 1'b1;
          if (bits_dec == '0) pins_nxt.latch_clock = 1'b0;
        end
        PH_LATCH: begin
          pins_nxt.shift_clock = 1'b0;
          // latch goes up ahead of the frame's last byte
          if (bsel_r == BSEL_W'(CHAIN_BYTES - 1)) pins_nxt.latch_clock = 1'b1;
        end
        default: begin
          pins_nxt.shift_clock = 1'b0;
          frame_nxt = build;
          grid_nxt  = (grid_cur >= GRID_AW'(NUM_GRIDS - 1)) ? '0 : grid_cur + 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    req          = '0;
    req.rd_en    = accept;
    req.rd_addr  = grid_cur;
    req.dig_we   = fire && (cmd == CMD_DIGIT) && (position < GRID_AW'(NUM_GRIDS));
    req.dig_addr = position;
    req.dig_data = digit;
    req.sym_we   = fire && (cmd == CMD_SYMBOL) && (sent.grid < 4'(GRID_STORE));
    req.sym_addr = sent.grid[GRID_AW-1:0];
    req.sym_sel  = sent.sel;
    req.sym_bits = sent.bits;
    req.blank    = fire && (cmd == CMD_BLANK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BUILD;
      for (int i = 0; i < CHAIN_BYTES; i++)
        frame_r[i] <= (i == CHAIN_BYTES - 1) ? 8'h03 : 8'h00;
      bsel_r  <= BSEL_W'(CHAIN_BYTES - 1);
      grid_r  <= '0;
      shift_r <= '0;
      bits_r  <= '0;
      pins_r  <= '{clear_n: 1'b1, latch_clock: 1'b0, shift_clock: 1'b0,
                   serial_data: 1'b0};
    end else begin
      phase_r <= phase_nxt;
      frame_r <= frame_nxt;
      bsel_r  <= bsel_nxt;
      grid_r  <= grid_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      pins_r  <= pins_nxt;
    end
  end

  a_build_to_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && phase_r == PH_BUILD) |=> phase_r == PH_CLEAR)
    else $error("frame build not followed by clear phase");

  a_sclk_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pins_r.shift_clock) |-> $past(tick && phase_r == PH_CLKHI))
    else $error("shift clock rose outside the clock-high phase");

  a_grid_range: assert property (@(posedge clk) disable iff (!rst_n)
    grid_r < GRID_AW'(NUM_GRIDS))
    else $error("grid index out of range");

endmodule

`default_nettype wire

/* rtl/vfd_grid_scan_shifter_unit.sv */
// Scan driver for a 7-grid vfd behind a chain of four 8-bit shift registers.
// Input channel in_*: one word per command (tick, write digit, write symbol,
// blank all). Every accepted word gives exactly one output word on out_*,
// the pin levels (data, shift clock, latch, clear) after that command.
// A word is accepted into a holding stage while the per-grid memories are
// read at the current grid; it is executed when it moves from the holding
// stage into the output register, which a receiver stall can hold off.
// Throughput is one word per cycle sustained while out_tready stays high.
// Writes to the grid being read in the same cycle are forwarded, so a digit
// or symbol write followed directly by a build tick is seen.
// Reset returns the sequencer to the frame build phase, clears the grid
// valid bits (digits read blank, no symbols) and sets clear_n high with
// the other pins low; the block takes words as soon as reset is released.
// When the receiver stalls, the output word holds and the holding stage
// fills; in_tready drops only when both are occupied and out_tready is low.
`default_nettype none

module vfd_grid_scan_shifter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // command[1:0], position[4:2], digit[8:5], symbol_id[11:9]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // serial_data[0], shift_clock[1], latch_clock[2], clear_n[3]
);
  import vgss_pkg::*;

  logic        accept;
  logic        b_fire;
  logic        b_valid_r;
  cmd_t        b_cmd_r;
  logic [2:0]  b_pos_r;
  logic [3:0]  b_digit_r;
  logic [2:0]  b_sym_r;
  logic        out_valid_r;
  pin_t        out_pins_r;
  pin_t        pins_nxt;
  store_req_t  req;
  grid_entry_t entry;

  assign b_fire    = b_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !b_valid_r || b_fire;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) b_valid_r <= 1'b1;
      else if (b_fire) b_valid_r <= 1'b0;
      if (b_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_cmd_r   <= cmd_t'(in_tdata[1:0]);
      b_pos_r   <= in_tdata[4:2];
      b_digit_r <= in_tdata[8:5];
      b_sym_r   <= in_tdata[11:9];
    end
    if (b_fire) out_pins_r <= pins_nxt;
  end

  vgss_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .fire      (b_fire),
    .cmd       (b_cmd_r),
    .position  (b_pos_r),
    .digit     (b_digit_r),
    .symbol_id (b_sym_r),
    .entry     (entry),
    .req       (req),
    .pins_nxt  (pins_nxt)
  );

  vgss_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .entry (entry)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_pins_r};

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire |=> out_valid_r)
    else $error("executed word did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_fire) |-> !accept)
    else $error("holding stage overwritten while occupied");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r && $stable(out_pins_r))
    else $error("output word changed while stalled");

endmodule

`default_nettype wire
